// File: src/ststs_pkg.sv
package ststs_pkg;

  localparam int POS_BITS_DEF   = 16;
  localparam int DEPTH_BITS_DEF = 8;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;

  localparam logic [FIELD_W-1:0] SPAN_LIMIT_RST = 16'hFFFF;
  localparam logic [FIELD_W-1:0] COUNT_MAX      = 16'hFFFF;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT     = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_W-1:0] CH_O      = 8'h6F;
  localparam logic [BYTE_W-1:0] CH_P      = 8'h70;
  localparam logic [BYTE_W-1:0] CH_S      = 8'h73;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_HIGH   = 8'h80;

  typedef struct packed {
    logic [FIELD_W-1:0] span_start;
    logic [FIELD_W-1:0] span_length;
    logic               is_summary;
    logic [FIELD_W-1:0] span_total;
    logic               status;
  } result_t;

endpackage

// File: src/ststs_in_if.sv
interface ststs_in_if;
  import ststs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: src/ststs_out_if.sv
interface ststs_out_if;
  import ststs_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] span_start;
  logic [FIELD_W-1:0] span_length;
  logic               is_summary;
  logic [FIELD_W-1:0] span_total;
  logic               status;

  modport source (output valid, output span_start, output span_length, output is_summary,
                  output span_total, output status, input ready);
  modport sink (input valid, input span_start, input span_length, input is_summary,
                input span_total, input status, output ready);
endinterface

// File: src/subtitle_text_span_scanner_core.sv
// Subtitle text span scanner.
// The input channel carries one text byte per beat, with end_of_text set on
// the last byte of a string. The result channel carries one span per beat
// (start offset and trimmed length) and, after the last byte, a summary beat
// with the span total and the status. A byte gives at most two result beats.
// The span limit register is written through cfg_we and cfg_wdata; the user is
// to write it only while the block is idle, which the block does not enforce.
// Spans beyond it are counted but not sent. Each accepted byte is parsed in
// the cycle it is taken; its results go into a four-entry result queue, which
// feeds the result channel. The block takes one byte every cycle as long as
// the queue has room for two results; the queue is the only limit on rate.
// When the receiver stalls, the queue fills and in_ch.ready drops once fewer
// than two entries are free; no result is lost.
// Reset clears the parser state and the queue and sets the span limit to
// 65535. After each summary the parser returns to its reset state, but the
// span limit is kept.
module subtitle_text_span_scanner_core #(
  parameter int POS_BITS   = ststs_pkg::POS_BITS_DEF,
  parameter int DEPTH_BITS = ststs_pkg::DEPTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ststs_in_if.sink                     in_ch,
  ststs_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [ststs_pkg::FIELD_W-1:0] cfg_wdata
);
  import ststs_pkg::*;

  localparam int LW = (POS_BITS > FIELD_W) ? POS_BITS : FIELD_W;
  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  typedef enum logic [3:0] {
    M_TEXT, M_ESC, M_BLK, M_NAME, M_P1, M_PO, M_PB, M_ARG0, M_NWS,
    M_NSIGN, M_NDIG, M_TAIL1, M_TAIL2, M_DONE
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  draw;
    logic [DEPTH_BITS-1:0] depth;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   first;
    logic [POS_BITS-1:0]   last;
    logic                  has;
    logic [FIELD_W-1:0]    cnt;
    logic                  f_par;
    logic                  f_neg;
    logic                  f_nz;
    logic                  err;
  } st_t;

  typedef struct packed {
    st_t                st;
    logic               emit;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
  } flush_t;

  function automatic logic is_sp(input logic [BYTE_W-1:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return b inside {[CH_0:CH_9]};
  endfunction

  function automatic st_t fail_f(input st_t s);
    st_t r;
    r = s;
    r.err = 1'b1;
    r.mode = M_DONE;
    return r;
  endfunction

  function automatic st_t blk_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t r;
    r = s;
    r.mode = M_BLK;
    if (b == CH_LPAREN) begin
      if (r.depth != {DEPTH_BITS{1'b1}}) r.depth = r.depth + 1'b1;
    end else if (b == CH_RPAREN) begin
      if (r.depth != '0) r.depth = r.depth - 1'b1;
    end else if (b == CH_BSLASH) begin
      r.mode = M_NAME;
    end else if (b == CH_RBRACE) begin
      r.mode = M_TEXT;
    end
    return r;
  endfunction

  function automatic st_t finish_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t  r;
    logic on;
    r = s;
    on = r.f_nz && !r.f_neg;
    if (b == CH_RBRACE) begin
      r.draw = on;
      r.mode = M_TEXT;
    end else if (b == CH_BSLASH) begin
      r.draw = on;
      r.mode = M_NAME;
    end else begin
      r = fail_f(r);
    end
    return r;
  endfunction

  function automatic st_t dig_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t r;
    r = s;
    if (b != CH_0) r.f_nz = 1'b1;
    r.mode = M_NDIG;
    return r;
  endfunction

  function automatic st_t sign_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t r;
    r = s;
    if (b == CH_MINUS) r.f_neg = 1'b1;
    r.mode = M_NSIGN;
    return r;
  endfunction

  function automatic st_t arg0_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t r;
    r = s;
    if (is_sp(b)) begin
      r.mode = M_ARG0;
    end else if (b == CH_LPAREN) begin
      r.f_par = 1'b1;
      r.mode = M_NWS;
    end else if ((b == CH_RBRACE) || (b == CH_BSLASH)) begin
      r = finish_f(r, b);
    end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
      r = sign_f(r, b);
    end else if (is_digit(b)) begin
      r = dig_f(r, b);
    end else if ((b == CH_VT) || (b == CH_FF)) begin
      r.mode = M_NWS;
    end else begin
      r = fail_f(r);
    end
    return r;
  endfunction

  function automatic st_t tail1_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t r;
    r = s;
    if (is_sp(b)) begin
      r.mode = M_TAIL1;
    end else if (r.f_par) begin
      if (b == CH_RPAREN) r.mode = M_TAIL2;
      else r = fail_f(r);
    end else begin
      r = finish_f(r, b);
    end
    return r;
  endfunction

  function automatic st_t scan_f(input st_t s, input logic [BYTE_W-1:0] b);
    st_t r;
    r = s;
    case (s.mode)
      M_ESC: r.mode = M_TEXT;
      M_BLK: r = blk_f(s, b);
      M_NAME: begin
        if (is_sp(b)) begin
          r = s;
        end else if (b == CH_P) begin
          r.f_par = 1'b0;
          r.f_neg = 1'b0;
          r.f_nz = 1'b0;
          r.mode = M_P1;
        end else begin
          r = blk_f(s, b);
        end
      end
      M_P1: begin
        if (b == CH_O) r.mode = M_PO;
        else if (b == CH_B) r.mode = M_PB;
        else if (s.depth != '0) r = fail_f(s);
        else r = arg0_f(s, b);
      end
      M_PO: r = (b == CH_S) ? blk_f(s, CH_NUL) : fail_f(s);
      M_PB: r = (b == CH_O) ? blk_f(s, CH_NUL) : fail_f(s);
      M_ARG0: r = arg0_f(s, b);
      M_NWS: begin
        if (is_sp(b) || (b == CH_VT) || (b == CH_FF)) r = s;
        else if ((b == CH_PLUS) || (b == CH_MINUS)) r = sign_f(s, b);
        else if (is_digit(b)) r = dig_f(s, b);
        else r = fail_f(s);
      end
      M_NSIGN: r = is_digit(b) ? dig_f(s, b) : fail_f(s);
      M_NDIG: r = is_digit(b) ? dig_f(s, b) : tail1_f(s, b);
      M_TAIL1: r = tail1_f(s, b);
      M_TAIL2: r = is_sp(b) ? s : finish_f(s, b);
      default: r.mode = M_DONE;
    endcase
    return r;
  endfunction

  function automatic flush_t flush_f(input st_t s, input logic [FIELD_W-1:0] limit);
    flush_t        f;
    logic [LW-1:0] first_w;
    logic [LW-1:0] len_w;
    f.st = s;
    f.emit = 1'b0;
    first_w = LW'(s.first);
    len_w = LW'(s.last) - LW'(s.first) + LW'(1);
    f.start = first_w[FIELD_W-1:0];
    f.len = len_w[FIELD_W-1:0];
    if (s.has) begin
      f.st.has = 1'b0;
      if (!s.draw) begin
        if (s.cnt == COUNT_MAX) begin
          f.st = fail_f(f.st);
        end else begin
          f.st.cnt = s.cnt + 1'b1;
          f.emit = (s.cnt < limit);
        end
      end
    end
    return f;
  endfunction

  function automatic flush_t close_f(input st_t s, input logic [FIELD_W-1:0] limit);
    flush_t f;
    f = flush_f(s, limit);
    if ((s.mode == M_TEXT) || (s.mode == M_ESC)) begin
      f.st.mode = M_DONE;
    end else begin
      f.emit = 1'b0;
      f.st = (s.mode == M_DONE) ? s : fail_f(s);
    end
    return f;
  endfunction

  st_t                st_r, st_nxt, st_clear;
  logic [FIELD_W-1:0] span_limit_r;
  result_t            queue_r [QD];
  logic [QA-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QA:0]        count_r, count_nxt;
  logic               in_fire, out_fire;
  logic               span_v, sum_v;
  result_t            span_res, sum_res, push0, push1;
  logic [1:0]         n_push;
  logic [POS_BITS-1:0] cur_pos;

  assign in_ch.ready = (count_r <= (QA+1)'(QD - 2));
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count_r != '0);
  assign out_fire = out_ch.valid && out_ch.ready;

  assign out_ch.span_start  = queue_r[rd_ptr_r].span_start;
  assign out_ch.span_length = queue_r[rd_ptr_r].span_length;
  assign out_ch.is_summary  = queue_r[rd_ptr_r].is_summary;
  assign out_ch.span_total  = queue_r[rd_ptr_r].span_total;
  assign out_ch.status      = queue_r[rd_ptr_r].status;

  always_comb begin
    st_t    s;
    flush_t f;
    logic [BYTE_W-1:0] b;
    b = in_ch.text_byte;
    s = st_r;
    f = '0;
    st_clear = '0;
    st_clear.mode = M_TEXT;
    span_v = 1'b0;
    span_res = '0;
    sum_v = 1'b0;
    sum_res = '0;
    cur_pos = s.pos;
    if (s.mode != M_DONE) begin
      if (b == CH_NUL) begin
        f = close_f(s, span_limit_r);
        s = f.st;
        if (f.emit) begin
          span_v = 1'b1;
          span_res.span_start = f.start;
          span_res.span_length = f.len;
          span_res.span_total = f.st.cnt;
        end
      end else if (s.pos == {POS_BITS{1'b1}}) begin
        s = fail_f(s);
      end else begin
        s.pos = s.pos + 1'b1;
        if ((s.mode == M_TEXT) || ((s.mode == M_ESC) && (b >= CH_HIGH))) begin
          s.mode = M_TEXT;
          if ((b == CH_LBRACE) || (b == CH_BSLASH)) begin
            f = flush_f(s, span_limit_r);
            s = f.st;
            if (f.emit) begin
              span_v = 1'b1;
              span_res.span_start = f.start;
              span_res.span_length = f.len;
              span_res.span_total = f.st.cnt;
            end
            if (s.mode != M_DONE) begin
              s.mode = (b == CH_LBRACE) ? M_BLK : M_ESC;
              s.depth = '0;
            end
          end else if (!is_sp(b)) begin
            if (!s.has) s.first = cur_pos;
            s.last = cur_pos;
            s.has = 1'b1;
          end
        end else begin
          s = scan_f(s, b);
        end
      end
    end
    if (in_ch.end_of_text) begin
      f = close_f(s, span_limit_r);
      s = f.st;
      if (f.emit) begin
        span_v = 1'b1;
        span_res.span_start = f.start;
        span_res.span_length = f.len;
        span_res.span_total = f.st.cnt;
      end
      sum_v = 1'b1;
      sum_res.is_summary = 1'b1;
      sum_res.span_total = s.cnt;
      sum_res.status = s.err;
      s = st_clear;
    end
    st_nxt = s;
  end

  always_comb begin
    push0 = span_v ? span_res : sum_res;
    push1 = sum_res;
    n_push = in_fire ? ({1'b0, span_v} + {1'b0, sum_v}) : 2'd0;
    count_nxt = count_r + (QA+1)'(n_push) - (QA+1)'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_clear;
      span_limit_r <= SPAN_LIMIT_RST;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      if (cfg_we) span_limit_r <= cfg_wdata;
      wr_ptr_r <= wr_ptr_r + QA'(n_push);
      if (out_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue_r[wr_ptr_r] <= push0;
    if (n_push == 2'd2) queue_r[wr_ptr_r + 1'b1] <= push1;
  end

endmodule

// File: verif/subtitle_span_checker.sv
`timescale 1ns / 1ps

module subtitle_span_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ststs_in_if                           in_mon,
  ststs_out_if                          out_mon,
  input  logic                          cfg_we,
  input  logic [ststs_pkg::FIELD_W-1:0] cfg_wdata,
  output int                            mismatch_count,
  output int                            expected_left
);
  import ststs_pkg::*;

  typedef enum logic [3:0] {
    SCAN_TEXT, SCAN_ESC, SCAN_BLOCK, SCAN_TAG_NAME, SCAN_TAG_P, SCAN_TAG_PO, SCAN_TAG_PB,
    SCAN_ARG_START, SCAN_ARG_SPACE, SCAN_ARG_SIGN, SCAN_ARG_DIGIT, SCAN_ARG_TAIL,
    SCAN_ARG_CLOSED, SCAN_DONE
  } scan_mode_t;

  localparam logic [DEPTH_BITS_DEF-1:0] DEPTH_MAX = '1;
  localparam logic [POS_BITS_DEF:0] POS_LIMIT =
    (POS_BITS_DEF+1)'((1 << POS_BITS_DEF) - 1);
  localparam int REPORT_MAX = 10;

  scan_mode_t                mode;
  logic                      drawing;
  logic [DEPTH_BITS_DEF-1:0] depth;
  logic [POS_BITS_DEF:0]     byte_pos;
  logic [FIELD_W-1:0]        run_first;
  logic [FIELD_W-1:0]        run_last;
  logic                      run_open;
  logic [FIELD_W-1:0]        span_count;
  logic                      arg_paren;
  logic                      arg_neg;
  logic                      arg_nonzero;
  logic                      error_seen;
  logic [FIELD_W-1:0]        span_limit;

  result_t expected_spans[$];
  int mismatches = 0;
  int outstanding = 0;

  assign mismatch_count = mismatches;
  assign expected_left  = outstanding;

  function automatic logic is_blank(logic [BYTE_W-1:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic is_digit(logic [BYTE_W-1:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic string beat_str(result_t r);
    return $sformatf("start=%0d len=%0d summary=%0b total=%0d status=%0b",
                     r.span_start, r.span_length, r.is_summary, r.span_total, r.status);
  endfunction

  function automatic void clear_scan();
    mode        = SCAN_TEXT;
    drawing     = 1'b0;
    depth       = '0;
    byte_pos    = '0;
    run_first   = '0;
    run_last    = '0;
    run_open    = 1'b0;
    span_count  = '0;
    arg_paren   = 1'b0;
    arg_neg     = 1'b0;
    arg_nonzero = 1'b0;
    error_seen  = 1'b0;
  endfunction

  function automatic void queue_result(logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] len,
                                       logic summary);
    result_t r;
    r.span_start  = summary ? '0 : start;
    r.span_length = summary ? '0 : len;
    r.is_summary  = summary;
    r.span_total  = span_count;
    r.status      = summary && error_seen;
    expected_spans.push_back(r);
  endfunction

  function automatic void stop_scan();
    error_seen = 1'b1;
    mode       = SCAN_DONE;
  endfunction

  function automatic void flush_run();
    if (!run_open) return;
    run_open = 1'b0;
    if (drawing) return;
    if (span_count == COUNT_MAX) begin
      stop_scan();
      return;
    end
    span_count = span_count + 16'd1;
    if (span_count - 16'd1 < span_limit)
      queue_result(run_first, run_last - run_first + 16'd1, 1'b0);
  endfunction

  function automatic void block_byte(logic [BYTE_W-1:0] b);
    mode = SCAN_BLOCK;
    if (b == CH_LPAREN) begin
      if (depth < DEPTH_MAX) depth = depth + 1'b1;
    end else if (b == CH_RPAREN) begin
      if (depth != '0) depth = depth - 1'b1;
    end else if (b == CH_BSLASH) begin
      mode = SCAN_TAG_NAME;
    end else if (b == CH_RBRACE) begin
      mode = SCAN_TEXT;
    end
  endfunction

  function automatic void close_tag(logic [BYTE_W-1:0] b);
    logic on;
    on = arg_nonzero && !arg_neg;
    if (b == CH_RBRACE) begin
      drawing = on;
      mode    = SCAN_TEXT;
    end else if (b == CH_BSLASH) begin
      drawing = on;
      mode    = SCAN_TAG_NAME;
    end else begin
      stop_scan();
    end
  endfunction

  function automatic void take_digit(logic [BYTE_W-1:0] b);
    if (b != CH_0) arg_nonzero = 1'b1;
    mode = SCAN_ARG_DIGIT;
  endfunction

  function automatic void take_sign(logic [BYTE_W-1:0] b);
    if (b == CH_MINUS) arg_neg = 1'b1;
    mode = SCAN_ARG_SIGN;
  endfunction

  function automatic void arg_start(logic [BYTE_W-1:0] b);
    if (is_blank(b)) begin
      mode = SCAN_ARG_START;
    end else if (b == CH_LPAREN) begin
      arg_paren = 1'b1;
      mode      = SCAN_ARG_SPACE;
    end else if (b == CH_RBRACE || b == CH_BSLASH) begin
      close_tag(b);
    end else if (b == CH_PLUS || b == CH_MINUS) begin
      take_sign(b);
    end else if (is_digit(b)) begin
      take_digit(b);
    end else if (b == CH_VT || b == CH_FF) begin
      mode = SCAN_ARG_SPACE;
    end else begin
      stop_scan();
    end
  endfunction

  function automatic void arg_tail(logic [BYTE_W-1:0] b);
    if (is_blank(b)) begin
      mode = SCAN_ARG_TAIL;
    end else if (arg_paren) begin
      if (b == CH_RPAREN) mode = SCAN_ARG_CLOSED;
      else stop_scan();
    end else begin
      close_tag(b);
    end
  endfunction

  function automatic void text_byte(logic [BYTE_W-1:0] b, logic [FIELD_W-1:0] p);
    if (b == CH_LBRACE || b == CH_BSLASH) begin
      flush_run();
      if (mode == SCAN_DONE) return;
      mode  = (b == CH_LBRACE) ? SCAN_BLOCK : SCAN_ESC;
      depth = '0;
    end else if (!is_blank(b)) begin
      if (!run_open) run_first = p;
      run_last = p;
      run_open = 1'b1;
    end
  endfunction

  function automatic void scan_byte(logic [BYTE_W-1:0] b, logic [FIELD_W-1:0] p);
    case (mode)
      SCAN_TEXT: text_byte(b, p);
      SCAN_ESC: begin
        mode = SCAN_TEXT;
        if (b >= CH_HIGH) text_byte(b, p);
      end
      SCAN_BLOCK: block_byte(b);
      SCAN_TAG_NAME: begin
        if (b == CH_P) begin
          arg_paren   = 1'b0;
          arg_neg     = 1'b0;
          arg_nonzero = 1'b0;
          mode        = SCAN_TAG_P;
        end else if (!is_blank(b)) begin
          block_byte(b);
        end
      end
      SCAN_TAG_P: begin
        if (b == CH_O) mode = SCAN_TAG_PO;
        else if (b == CH_B) mode = SCAN_TAG_PB;
        else if (depth != '0) stop_scan();
        else arg_start(b);
      end
      SCAN_TAG_PO: if (b == CH_S) mode = SCAN_BLOCK; else stop_scan();
      SCAN_TAG_PB: if (b == CH_O) mode = SCAN_BLOCK; else stop_scan();
      SCAN_ARG_START: arg_start(b);
      SCAN_ARG_SPACE: begin
        if (b == CH_PLUS || b == CH_MINUS) take_sign(b);
        else if (is_digit(b)) take_digit(b);
        else if (!(is_blank(b) || b == CH_VT || b == CH_FF)) stop_scan();
      end
      SCAN_ARG_SIGN: if (is_digit(b)) take_digit(b); else stop_scan();
      SCAN_ARG_DIGIT: if (is_digit(b)) take_digit(b); else arg_tail(b);
      SCAN_ARG_TAIL: arg_tail(b);
      SCAN_ARG_CLOSED: if (!is_blank(b)) close_tag(b);
      default: mode = SCAN_DONE;
    endcase
  endfunction

  function automatic void close_text();
    if (mode == SCAN_TEXT || mode == SCAN_ESC) begin
      flush_run();
      mode = SCAN_DONE;
    end else if (mode != SCAN_DONE) begin
      stop_scan();
    end
  endfunction

  function automatic void predict_spans(logic [BYTE_W-1:0] b, logic is_last);
    logic [FIELD_W-1:0] p;
    if (mode != SCAN_DONE) begin
      if (b == CH_NUL) begin
        close_text();
      end else if (byte_pos >= POS_LIMIT) begin
        stop_scan();
      end else begin
        p        = byte_pos[FIELD_W-1:0];
        byte_pos = byte_pos + 1'b1;
        scan_byte(b, p);
      end
    end
    if (is_last) begin
      close_text();
      queue_result('0, '0, 1'b1);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_scan();
      span_limit = SPAN_LIMIT_RST;
      expected_spans.delete();
    end else begin
      if (cfg_we) span_limit = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got.span_start  = out_mon.span_start;
        got.span_length = out_mon.span_length;
        got.is_summary  = out_mon.is_summary;
        got.span_total  = out_mon.span_total;
        got.status      = out_mon.status;
        if (expected_spans.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected result beat %s", $realtime, beat_str(got));
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          if (got.span_start !== want.span_start || got.span_length !== want.span_length ||
              got.is_summary !== want.is_summary || got.span_total !== want.span_total ||
              got.status !== want.status) begin
            if (mismatches < REPORT_MAX)
              $display("%0t: mismatch expected %s, got %s", $realtime, beat_str(want),
                       beat_str(got));
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_spans(in_mon.text_byte, in_mon.end_of_text);
    end
    outstanding = expected_spans.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ststs_pkg::*;

  localparam int ITEMS_PER_PHASE = 110;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TIMEOUT_NS      = 2_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               tx_valid = 1'b0;
  logic [BYTE_W-1:0]  tx_byte = '0;
  logic               tx_eot = 1'b0;
  logic               rx_ready = 1'b0;
  logic               cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  int mismatch_count;
  int expected_left;

  logic [BYTE_W-1:0] text_buf[$];

  ststs_in_if  in_ch ();
  ststs_out_if out_ch ();

  assign in_ch.valid       = tx_valid;
  assign in_ch.text_byte   = tx_byte;
  assign in_ch.end_of_text = tx_eot;
  assign out_ch.ready      = rx_ready;

  subtitle_text_span_scanner_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  subtitle_span_checker span_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
  end

  function automatic logic [BYTE_W-1:0] rand_byte(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void add_blanks(int lo);
    repeat ($urandom_range(3, lo)) begin
      case ($urandom_range(3, 0))
        0: text_buf.push_back(CH_SP);
        1: text_buf.push_back(CH_TAB);
        2: text_buf.push_back(CH_CR);
        default: text_buf.push_back(CH_LF);
      endcase
    end
  endfunction

  // Mostly well-formed text runs and override blocks, with some noise and broken blocks.
  function automatic void add_random_text();
    int r;
    bit paren;
    bit signed_arg;
    int digits;
    repeat ($urandom_range(8, 1)) begin
      r = $urandom_range(99, 0);
      if (r < 35) begin
        repeat ($urandom_range(5, 1)) begin
          case ($urandom_range(3, 0))
            0: text_buf.push_back(8'h61 + rand_byte(0, 25));
            1: text_buf.push_back(8'h41 + rand_byte(0, 25));
            2: text_buf.push_back(CH_0 + rand_byte(0, 9));
            default: text_buf.push_back(rand_byte(128, 255));
          endcase
        end
      end else if (r < 55) begin
        add_blanks(1);
      end else if (r < 65) begin
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back(rand_byte(1, 255));
      end else if (r < 85) begin
        text_buf.push_back(CH_LBRACE);
        repeat ($urandom_range(2, 0)) begin
          case ($urandom_range(3, 0))
            0: add_str("\\pos(12,34)");
            1: add_str("\\pbo4");
            2: add_str("\\b1");
            default: add_str("(x)");
          endcase
        end
        repeat ($urandom_range(2, 0)) begin
          text_buf.push_back(CH_BSLASH);
          if ($urandom_range(99, 0) < 20) text_buf.push_back(CH_SP);
          text_buf.push_back(CH_P);
          paren = ($urandom_range(99, 0) < 30);
          if (paren) text_buf.push_back(CH_LPAREN);
          if ($urandom_range(99, 0) < 15) begin
            case ($urandom_range(2, 0))
              0: text_buf.push_back(CH_SP);
              1: text_buf.push_back(CH_VT);
              default: text_buf.push_back(CH_FF);
            endcase
          end
          signed_arg = ($urandom_range(99, 0) < 25);
          if (signed_arg) text_buf.push_back($urandom_range(1, 0) ? CH_MINUS : CH_PLUS);
          digits = (paren || signed_arg) ? $urandom_range(3, 1) : $urandom_range(3, 0);
          repeat (digits) begin
            if ($urandom_range(99, 0) < 40) text_buf.push_back(CH_0);
            else text_buf.push_back(CH_0 + rand_byte(1, 9));
          end
          if (paren) text_buf.push_back(CH_RPAREN);
          add_blanks(0);
        end
        if ($urandom_range(99, 0) < 92) text_buf.push_back(CH_RBRACE);
      end else if (r < 95) begin
        text_buf.push_back(rand_byte(1, 255));
      end else begin
        text_buf.push_back(CH_NUL);
        repeat ($urandom_range(2, 0)) text_buf.push_back(rand_byte(0, 255));
      end
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      tx_valid <= 1'b0;
      @(posedge clk);
    end
    tx_valid <= 1'b1;
    tx_byte  <= b;
    tx_eot   <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic settle();
    tx_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_span_limit(input logic [FIELD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int start_count;
    logic [FIELD_W-1:0] lim;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    text_buf.push_back(8'hFF);
    add_str(" a");
    text_buf.push_back(CH_TAB);
    add_str("b\\n\\");
    text_buf.push_back(CH_HIGH);
    add_str("{\\p1}x{\\p0}");
    text_buf.push_back(CH_CR);
    send_text();
    add_str("{)\\pos(1)\\p(-2)}y");
    text_buf.push_back(CH_NUL);
    add_str("q");
    send_text();
    add_str("{\\p");
    text_buf.push_back(CH_VT);
    add_str("}");
    send_text();
    add_str("{(\\p1}");
    send_text();
    add_str("{a");
    send_text();
    text_buf.push_back(CH_NUL);
    send_text();
    text_buf.push_back(CH_BSLASH);
    text_buf.push_back(8'h7F);
    add_str("z");
    send_text();

    // This string saturates the paren depth.
    settle();
    set_span_limit(16'd0);
    text_buf.push_back(CH_LBRACE);
    repeat (256) text_buf.push_back(CH_LPAREN);
    repeat (255) text_buf.push_back(CH_RPAREN);
    add_str("\\p1}ab");
    send_text();

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      case (ph)
        0: lim = 16'hFFFF;
        1: lim = 16'd1;
        2: lim = 16'd0;
        3: lim = 16'd3;
        4: lim = 16'd2;
        5: lim = 16'hFFFF;
        6: lim = 16'($urandom_range(5, 0));
        default: lim = 16'd4;
      endcase
      set_span_limit(lim);
      start_count = items_sent;
      while (items_sent - start_count < ITEMS_PER_PHASE) begin
        add_random_text();
        send_text();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASS subtitle_text_span_scanner_core");
    end else begin
      $display("FAIL subtitle_text_span_scanner_core");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL subtitle_text_span_scanner_core");
    $finish;
  end

endmodule
